### rtl/core/fqd_pkg.sv
// shared types and codes for the fifo queue with delete-by-value
package fqd_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_DEL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ADDR_CUR  = 2'd0,
    ADDR_PREV = 2'd1,
    ADDR_TAIL = 2'd2
  } addr_sel_e;

  typedef struct packed {
    logic      req_load;
    logic      cur_clr;
    logic      cur_inc;
    addr_sel_e addr_sel;
    logic      wr_en;
    logic      wr_from_rdata;
    logic      occ_inc;
    logic      occ_dec;
    logic      head_inc;
    logic      res_valid;
    logic      res_status;
    logic      res_take_rdata;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hnull;
    logic       full;
    logic       empty;
    logic       hit;
    logic       last;
  } stat_t;

endpackage

### rtl/core/fqd_ctrl.sv
// sequencer that takes each request through dispatch and its dequeue, scan or shift phases
module fqd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  fqd_pkg::stat_t stat_i,
  output fqd_pkg::cmd_t  cmd_o
);
  import fqd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_DEQ      = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CMP = 7'b0010000,
    S_SH_RD    = 7'b0100000,
    S_SH_WR    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.addr_sel = ADDR_CUR;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.req_load = 1'b1;
          cmd_o.cur_clr  = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.kind)
          KIND_ENQ: begin
            cmd_o.res_valid = 1'b1;
            state_d         = S_IDLE;
            if (stat_i.hnull || stat_i.full) begin
              cmd_o.res_status = 1'b1;
            end else begin
              cmd_o.addr_sel = ADDR_TAIL;
              cmd_o.wr_en    = 1'b1;
              cmd_o.occ_inc  = 1'b1;
            end
          end
          KIND_DEQ: begin
            if (stat_i.empty) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = 1'b1;
              state_d          = S_IDLE;
            end else begin
              state_d = S_DEQ;
            end
          end
          KIND_DEL: begin
            if (stat_i.hnull || stat_i.empty) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = 1'b1;
              state_d          = S_IDLE;
            end else begin
              state_d = S_SCAN_CMP;
            end
          end
          default: begin
            cmd_o.res_valid  = 1'b1;
            cmd_o.res_status = 1'b1;
            state_d          = S_IDLE;
          end
        endcase
      end
      S_DEQ: begin
        cmd_o.res_valid      = 1'b1;
        cmd_o.res_take_rdata = 1'b1;
        cmd_o.head_inc       = 1'b1;
        cmd_o.occ_dec        = 1'b1;
        state_d              = S_IDLE;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.hit) begin
          if (stat_i.last) begin
            cmd_o.occ_dec   = 1'b1;
            cmd_o.res_valid = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.cur_inc = 1'b1;
            state_d       = S_SH_RD;
          end
        end else if (stat_i.last) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.cur_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.addr_sel      = ADDR_PREV;
        cmd_o.wr_en         = 1'b1;
        cmd_o.wr_from_rdata = 1'b1;
        if (stat_i.last) begin
          cmd_o.occ_dec   = 1'b1;
          cmd_o.res_valid = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.cur_inc = 1'b1;
          state_d       = S_SH_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/fqd_datapath.sv
// circular entry memory, pointers, request and result registers
module fqd_datapath #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     kind_i,
  input  logic [31:0]    handle_in_i,
  input  fqd_pkg::cmd_t  cmd_i,
  output fqd_pkg::stat_t stat_o,
  output logic           done_o,
  output logic           status_o,
  output logic [31:0]    handle_out_o,
  output logic [4:0]     count_o
);
  import fqd_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;
  logic [1:0]    kind_q;
  logic [31:0]   handle_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] occ_q;
  logic [CW-1:0] cur_q;
  logic          done_q;
  logic          res_status_q;
  logic [31:0]   res_handle_q;

  logic [CW-1:0] idx;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  logic [IW-1:0] addr;
  logic [31:0]   wdata;
  logic [SW-1:0] head_nxt;
  logic [31:0]   occ_ext;

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_CUR:  idx = cur_q;
      ADDR_PREV: idx = cur_q - CW'(1);
      ADDR_TAIL: idx = occ_q;
      default:   idx = cur_q;
    endcase
  end

  // logical slot to physical address, head plus index modulo depth
  assign sum     = SW'(head_q) + SW'(idx);
  assign wrapped = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
  assign addr    = wrapped[IW-1:0];
  assign wdata   = cmd_i.wr_from_rdata ? rdata_q : handle_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q   <= kind_i;
      handle_q <= handle_in_i;
    end
    if (cmd_i.res_valid) begin
      res_status_q <= cmd_i.res_status;
      res_handle_q <= cmd_i.res_take_rdata ? rdata_q : 32'd0;
    end
  end

  assign head_nxt = SW'(head_q) + SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      cur_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_valid;
      if (cmd_i.cur_clr) begin
        cur_q <= '0;
      end else if (cmd_i.cur_inc) begin
        cur_q <= cur_q + CW'(1);
      end
      if (cmd_i.occ_inc) begin
        occ_q <= occ_q + CW'(1);
      end else if (cmd_i.occ_dec) begin
        occ_q <= occ_q - CW'(1);
      end
      if (cmd_i.head_inc) begin
        head_q <= (head_nxt >= SW'(DEPTH)) ? '0 : head_nxt[IW-1:0];
      end
    end
  end

  assign stat_o.kind  = kind_q;
  assign stat_o.hnull = (handle_q == 32'd0);
  assign stat_o.full  = (occ_q == CW'(DEPTH));
  assign stat_o.empty = (occ_q == '0);
  assign stat_o.hit   = (rdata_q == handle_q);
  assign stat_o.last  = ((SW'(cur_q) + SW'(1)) >= SW'(occ_q));

  assign occ_ext      = 32'(occ_q);
  assign done_o       = done_q;
  assign status_o     = res_status_q;
  assign handle_out_o = res_handle_q;
  assign count_o      = occ_ext[4:0];

endmodule

### rtl/core/fifo_queue_with_delete_unit.sv
// top level of the fifo queue of nonzero handles with delete-by-value
//
// a request is kind_i (0 enqueue, 1 dequeue, 2 delete) and handle_in_i,
// taken at a rising edge with start_i high and busy_o low. busy_o stays
// high until the result is issued. each request gives one result on
// status_o, handle_out_o and count_o, marked by done_o for one cycle;
// the receiver cannot stall it. a new request may start in the cycle
// that done_o is high.
// entries sit in a circular memory whose read and write share one address.
// enqueue and the errors found at dispatch give their result from the
// dispatch state, dequeue from the dequeue state after it. delete compares
// entries from the head, with a read state before each but the first, then
// moves each later entry up one slot through a read state and a write state.
// status_o is 1 on an unused kind, full, empty, no match or null handle.
// count_o is the entry count after the request, low 5 bits.
// reset empties the queue at once; no clearing pass is needed.
module fifo_queue_with_delete_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] handle_in_i,
  output logic        done_o,
  output logic        status_o,
  output logic [31:0] handle_out_o,
  output logic [4:0]  count_o
);
  import fqd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fqd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  fqd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .handle_in_i  (handle_in_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .done_o       (done_o),
    .status_o     (status_o),
    .handle_out_o (handle_out_o),
    .count_o      (count_o)
  );

endmodule

### sim/tb_top.sv
// self-checking testbench for the fifo queue with delete-by-value unit
module tb_top;
  import fqd_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] handle;
    logic [4:0]  count;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  kind_i = KIND_ENQ;
  logic [31:0] handle_in_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        status_o;
  logic [31:0] handle_out_o;
  logic [4:0]  count_o;

  fifo_queue_with_delete_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .handle_in_i (handle_in_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .count_o     (count_o)
  );

  always #2 clk_i = ~clk_i;

  logic [31:0] held_q[$];
  result_t     pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_enq = 0, n_deq = 0, n_del = 0, n_unused = 0;
  int          n_ok = 0, n_err = 0, peak_count = 0;

  // queue occupancy after one request, and what the unit must report
  function automatic result_t predict_result(input logic [1:0] kind, input logic [31:0] h);
    result_t r;
    int      pos;
    r.kind   = kind;
    r.status = 1'b1;
    r.handle = '0;
    pos      = -1;
    case (kind)
      KIND_ENQ: begin
        if (h != 0 && held_q.size() < DEPTH) begin
          held_q.push_back(h);
          r.status = 1'b0;
        end
      end
      KIND_DEQ: begin
        if (held_q.size() != 0) begin
          r.handle = held_q.pop_front();
          r.status = 1'b0;
        end
      end
      KIND_DEL: begin
        if (h != 0) begin
          for (int i = 0; i < held_q.size(); i++)
            if (pos < 0 && held_q[i] == h) pos = i;
          if (pos >= 0) begin
            held_q.delete(pos);
            r.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(held_q.size());
    return r;
  endfunction

  // result check first, then prediction for a request taken at this edge
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result status %0d handle %h count %0d",
                   $time, status_o, handle_out_o, count_o);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (handle_out_o !== want.handle) begin
            $display("%0t: handle_out expected %h actual %h", $time, want.handle,
                     handle_out_o);
            errors++;
          end
          if (count_o !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, count_o);
            errors++;
          end
          case (want.kind)
            KIND_ENQ: n_enq++;
            KIND_DEQ: n_deq++;
            KIND_DEL: n_del++;
            default:  n_unused++;
          endcase
          if (want.status) n_err++;
          else n_ok++;
          if (int'(want.count) > peak_count) peak_count = int'(want.count);
        end
      end
      if (start_i && !busy_o) pending_q.push_back(predict_result(kind_i, handle_in_i));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [31:0] h);
    start_i     <= 1'b1;
    kind_i      <= kind;
    handle_in_i <= h;
    @(posedge clk_i);
    while (!(start_i && !busy_o)) @(posedge clk_i);
  endtask

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // mix of null, small duplicate-prone values, extremes and wide random handles
  function automatic logic [31:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll <= 3) return 32'($urandom_range(1, 6));
    if (roll == 4) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
    return $urandom();
  endfunction

  task automatic run_random(input int n, input int enq_pct, input bit gaps);
    int          roll;
    logic [1:0]  kind;
    logic [31:0] h;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        kind = KIND_ENQ;
        h    = pick_handle();
      end else if (roll < enq_pct + (100 - enq_pct) / 2) begin
        kind = KIND_DEQ;
        h    = $urandom();
      end else begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          kind = KIND_UNUSED;
          h    = $urandom();
        end else if (roll <= 2 || held_q.size() == 0) begin
          kind = KIND_DEL;
          h    = pick_handle();
        end else begin
          kind = KIND_DEL;
          h    = held_q[$urandom_range(0, held_q.size() - 1)];
        end
      end
      send_req(kind, h);
      if (gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
    end
  endtask

  task automatic test_corners();
    send_req(KIND_DEQ, 32'h0000_0000);
    send_req(KIND_DEL, 32'h0000_0005);
    send_req(KIND_ENQ, 32'h0000_0000);
    send_req(KIND_DEL, 32'h0000_0000);
    send_req(KIND_UNUSED, 32'hFFFF_FFFF);
    send_req(KIND_ENQ, 32'hFFFF_FFFF);
    send_req(KIND_ENQ, 32'h0000_0001);
    send_req(KIND_ENQ, 32'h8000_0000);
    send_req(KIND_ENQ, 32'h0000_0001);
    for (int i = 0; i < 12; i++) send_req(KIND_ENQ, 32'h1000_0000 + 32'(i));
    // store is full now
    send_req(KIND_ENQ, 32'h0000_0007);
    // duplicate, middle, head, tail, absent
    send_req(KIND_DEL, 32'h0000_0001);
    send_req(KIND_DEL, 32'h1000_0005);
    send_req(KIND_DEL, 32'hFFFF_FFFF);
    send_req(KIND_DEL, 32'h1000_000B);
    send_req(KIND_DEL, 32'h1234_5678);
    send_req(KIND_DEQ, 32'hA5A5_A5A5);
  endtask

  task automatic test_fill_heavy();
    run_random(500, 65, 1'b1);
  endtask

  task automatic test_drain_heavy();
    run_random(450, 25, 1'b1);
  endtask

  task automatic test_mixed_traffic();
    run_random(600, 45, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_random(400, 50, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_fill_heavy();
    test_drain_heavy();
    test_mixed_traffic();
    test_back_to_back();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("checked %0d enqueue, %0d dequeue, %0d delete and %0d unused-code requests",
             n_enq, n_deq, n_del, n_unused);
    $display("%0d succeeded, %0d rejected, peak occupancy %0d of %0d",
             n_ok, n_err, peak_count, DEPTH);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
